/* hw/rtl/voxel_face_culling_top_assert.svh */
`ifndef VOXEL_FACE_CULLING_TOP_ASSERT_SVH
`define VOXEL_FACE_CULLING_TOP_ASSERT_SVH

// same-cycle implication under reset
`define VFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define VFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vfc_pkg.sv */
package vfc_pkg;

  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 16;
  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int CRD_W = 4;
  localparam int TYPE_W = 8;
  localparam int FV_W = 17;
  localparam int SIDE_W = 3;
  localparam int NUM_SIDES = 6;
  localparam int VERTS_PER_FACE = 4;
  localparam logic [TYPE_W-1:0] SOLID_TYPE = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] AIR_TYPE = '0;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CULL  = 2'd2,
    OP_BEGIN = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_CULL,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [CRD_W-1:0]  z;
    logic [TYPE_W-1:0] btype;
    logic              on_grid;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CRD_W-1:0] x,
                                                  input logic [CRD_W-1:0] y,
                                                  input logic [CRD_W-1:0] z);
    cell_addr = ADDR_W'((int'(x) * GRID_Y + int'(y)) * GRID_Z + int'(z));
  endfunction

endpackage

/* hw/rtl/vfc_front.sv */
module vfc_front (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [vfc_pkg::CRD_W-1:0]  in_cell_x,
  input  logic [vfc_pkg::CRD_W-1:0]  in_cell_y,
  input  logic [vfc_pkg::CRD_W-1:0]  in_cell_z,
  input  logic [vfc_pkg::TYPE_W-1:0] in_block_type,
  input  logic                       clr_busy,
  input  logic                       q_ready,
  output logic                       q_push,
  output vfc_pkg::cmd_t              q_cmd
);

  logic on_grid;

  assign on_grid = (int'(in_cell_x) < vfc_pkg::GRID_X) &&
                   (int'(in_cell_y) < vfc_pkg::GRID_Y) &&
                   (int'(in_cell_z) < vfc_pkg::GRID_Z);

  assign in_stall = clr_busy || !q_ready;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_cmd.op      = vfc_pkg::op_t'(in_func);
    q_cmd.x       = in_cell_x;
    q_cmd.y       = in_cell_y;
    q_cmd.z       = in_cell_z;
    q_cmd.btype   = in_block_type;
    q_cmd.on_grid = on_grid;
    q_cmd.addr    = vfc_pkg::cell_addr(in_cell_x, in_cell_y, in_cell_z);
  end

endmodule

/* hw/rtl/vfc_queue.sv */
module vfc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vfc_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output vfc_pkg::cmd_t head
);

  vfc_pkg::cmd_t               ent_r [vfc_pkg::Q_DEPTH];
  logic [vfc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [vfc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [vfc_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        do_push, do_pop;

  assign ready   = count_r != vfc_pkg::QCNT_W'(vfc_pkg::Q_DEPTH);
  assign valid   = count_r != '0;
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == vfc_pkg::QPTR_W'(vfc_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + vfc_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == vfc_pkg::QPTR_W'(vfc_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + vfc_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + vfc_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - vfc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/vfc_back.sv */
module vfc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  vfc_pkg::cmd_t              q_head,
  output logic                       q_pop,
  output logic                       clr_busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_kind,
  output logic [vfc_pkg::SIDE_W-1:0] out_face_side,
  output logic [vfc_pkg::CRD_W-1:0]  out_face_x,
  output logic [vfc_pkg::CRD_W-1:0]  out_face_y,
  output logic [vfc_pkg::CRD_W-1:0]  out_face_z,
  output logic [vfc_pkg::FV_W-1:0]   out_first_vertex,
  output logic [vfc_pkg::TYPE_W-1:0] out_read_type,
  output logic                       out_last
);

  localparam int MASK_W = 2 * vfc_pkg::NUM_SIDES;
  localparam int SEL_W = $clog2(MASK_W);

  logic [vfc_pkg::TYPE_W-1:0] mem [vfc_pkg::DEPTH];
  logic [vfc_pkg::TYPE_W-1:0] mem_q_r;
  logic                       mem_we;
  logic [vfc_pkg::ADDR_W-1:0] mem_wa, mem_ra;
  logic [vfc_pkg::TYPE_W-1:0] mem_wd;

  logic                       clr_busy_r;
  logic [vfc_pkg::ADDR_W-1:0] clr_cnt_r;

  vfc_pkg::state_t            st_r, st_nxt;
  vfc_pkg::cmd_t              cmd_r;
  logic [2:0]                 step_r;
  logic [vfc_pkg::NUM_SIDES-1:0] air_r, air_nxt, bnd_r, inb;
  logic [MASK_W-1:0]          mask_r;
  logic [vfc_pkg::FV_W-1:0]   cnt_r;

  logic                       slot_free, load_read, load_face, face_last;
  logic [SEL_W-1:0]           sel;
  logic [vfc_pkg::SIDE_W-1:0] sel_side;
  logic [vfc_pkg::CRD_W-1:0]  nx, ny, nz;

  logic                       ov_r;
  logic                       kind_r, last_r;
  logic [vfc_pkg::SIDE_W-1:0] side_r;
  logic [vfc_pkg::CRD_W-1:0]  fx_r, fy_r, fz_r;
  logic [vfc_pkg::FV_W-1:0]   fv_r;
  logic [vfc_pkg::TYPE_W-1:0] rt_r;

  assign clr_busy  = clr_busy_r;
  assign slot_free = !ov_r || !out_stall;
  assign face_last = (mask_r & (mask_r - MASK_W'(1))) == '0;

  assign inb[0] = cmd_r.x != '0;
  assign inb[1] = int'(cmd_r.x) + 1 < vfc_pkg::GRID_X;
  assign inb[2] = cmd_r.y != '0;
  assign inb[3] = int'(cmd_r.y) + 1 < vfc_pkg::GRID_Y;
  assign inb[4] = cmd_r.z != '0;
  assign inb[5] = int'(cmd_r.z) + 1 < vfc_pkg::GRID_Z;

  always_comb begin
    nx = cmd_r.x;
    ny = cmd_r.y;
    nz = cmd_r.z;
    case (step_r)
      3'd0: nx = cmd_r.x - vfc_pkg::CRD_W'(1);
      3'd1: nx = cmd_r.x + vfc_pkg::CRD_W'(1);
      3'd2: ny = cmd_r.y - vfc_pkg::CRD_W'(1);
      3'd3: ny = cmd_r.y + vfc_pkg::CRD_W'(1);
      3'd4: nz = cmd_r.z - vfc_pkg::CRD_W'(1);
      3'd5: nz = cmd_r.z + vfc_pkg::CRD_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    sel = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = SEL_W'(i);
      end
    end
    sel_side = (int'(sel) >= vfc_pkg::NUM_SIDES) ?
               vfc_pkg::SIDE_W'(int'(sel) - vfc_pkg::NUM_SIDES) : vfc_pkg::SIDE_W'(sel);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      vfc_pkg::S_IDLE: begin
        if (!clr_busy_r && q_valid) st_nxt = vfc_pkg::S_EXEC;
      end
      vfc_pkg::S_EXEC: begin
        case (cmd_r.op)
          vfc_pkg::OP_READ: st_nxt = vfc_pkg::S_RDATA;
          vfc_pkg::OP_CULL: st_nxt = cmd_r.on_grid ? vfc_pkg::S_CULL : vfc_pkg::S_IDLE;
          default:          st_nxt = vfc_pkg::S_IDLE;
        endcase
      end
      vfc_pkg::S_RDATA: begin
        if (slot_free) st_nxt = vfc_pkg::S_IDLE;
      end
      vfc_pkg::S_CULL: begin
        if (step_r == 3'd0 && mem_q_r == vfc_pkg::AIR_TYPE) begin
          st_nxt = vfc_pkg::S_IDLE;
        end else if (step_r == 3'(vfc_pkg::NUM_SIDES)) begin
          st_nxt = vfc_pkg::S_EMIT;
        end
      end
      vfc_pkg::S_EMIT: begin
        if (mask_r == '0 || (slot_free && face_last)) st_nxt = vfc_pkg::S_IDLE;
      end
      default: st_nxt = vfc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = clr_busy_r;
    mem_wa    = clr_cnt_r;
    mem_wd    = vfc_pkg::SOLID_TYPE;
    mem_ra    = cmd_r.addr;
    load_read = 1'b0;
    load_face = 1'b0;
    air_nxt   = air_r;
    case (st_r)
      vfc_pkg::S_IDLE: begin
        q_pop = !clr_busy_r && q_valid;
      end
      vfc_pkg::S_EXEC: begin
        if (cmd_r.op == vfc_pkg::OP_WRITE && cmd_r.on_grid) begin
          mem_we = 1'b1;
          mem_wa = cmd_r.addr;
          mem_wd = cmd_r.btype;
        end
      end
      vfc_pkg::S_RDATA: begin
        load_read = slot_free;
      end
      vfc_pkg::S_CULL: begin
        mem_ra = vfc_pkg::cell_addr(nx, ny, nz);
        if (step_r != 3'd0) begin
          air_nxt[step_r - 3'd1] = inb[step_r - 3'd1] && (mem_q_r == vfc_pkg::AIR_TYPE);
        end
      end
      vfc_pkg::S_EMIT: begin
        load_face = slot_free && (mask_r != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      st_r       <= vfc_pkg::S_IDLE;
      cnt_r      <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + vfc_pkg::ADDR_W'(1);
        if (clr_cnt_r == vfc_pkg::ADDR_W'(vfc_pkg::DEPTH - 1)) clr_busy_r <= 1'b0;
      end
      st_r <= st_nxt;
      if (st_r == vfc_pkg::S_EXEC && cmd_r.op == vfc_pkg::OP_BEGIN) begin
        cnt_r <= '0;
      end else if (load_face) begin
        cnt_r <= cnt_r + vfc_pkg::FV_W'(vfc_pkg::VERTS_PER_FACE);
      end
      if (load_read || load_face) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (st_r == vfc_pkg::S_EXEC) begin
      step_r <= 3'd0;
      bnd_r  <= ~inb;
      air_r  <= '0;
    end
    if (st_r == vfc_pkg::S_CULL) begin
      step_r <= step_r + 3'd1;
      air_r  <= air_nxt;
      if (step_r == 3'(vfc_pkg::NUM_SIDES)) begin
        mask_r <= {air_nxt, bnd_r};
      end
    end
    if (load_face) begin
      mask_r <= mask_r & (mask_r - MASK_W'(1));
    end
    if (load_read) begin
      kind_r <= 1'b1;
      side_r <= '0;
      fx_r   <= '0;
      fy_r   <= '0;
      fz_r   <= '0;
      fv_r   <= '0;
      rt_r   <= cmd_r.on_grid ? mem_q_r : vfc_pkg::AIR_TYPE;
      last_r <= 1'b1;
    end else if (load_face) begin
      kind_r <= 1'b0;
      side_r <= sel_side;
      fx_r   <= cmd_r.x;
      fy_r   <= cmd_r.y;
      fz_r   <= cmd_r.z;
      fv_r   <= cnt_r;
      rt_r   <= '0;
      last_r <= face_last;
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = kind_r;
  assign out_face_side    = side_r;
  assign out_face_x       = fx_r;
  assign out_face_y       = fy_r;
  assign out_face_z       = fz_r;
  assign out_first_vertex = fv_r;
  assign out_read_type    = rt_r;
  assign out_last         = last_r;

endmodule

/* hw/rtl/voxel_face_culling_top.sv */
// Flow: the back end pops a transaction from the queue head into its command register and executes it;
// a read result is loaded into the output register, a cull reads the cell, then its neighbors, then emits any faces.
// Each transaction finishes before the next is popped; a cull is paced by the single read port
// of the voxel memory, which reads the cell and its six neighbors one per cycle.
// Reset: synchronous; afterwards a pass fills every cell of the grid with solid, in_stall high.
`include "voxel_face_culling_top_assert.svh"

module voxel_face_culling_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [vfc_pkg::CRD_W-1:0]  in_cell_x,
  input  logic [vfc_pkg::CRD_W-1:0]  in_cell_y,
  input  logic [vfc_pkg::CRD_W-1:0]  in_cell_z,
  input  logic [vfc_pkg::TYPE_W-1:0] in_block_type,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_kind,
  output logic [vfc_pkg::SIDE_W-1:0] out_face_side,
  output logic [vfc_pkg::CRD_W-1:0]  out_face_x,
  output logic [vfc_pkg::CRD_W-1:0]  out_face_y,
  output logic [vfc_pkg::CRD_W-1:0]  out_face_z,
  output logic [vfc_pkg::FV_W-1:0]   out_first_vertex,
  output logic [vfc_pkg::TYPE_W-1:0] out_read_type,
  output logic                       out_last
);

  logic          clr_busy, q_ready, q_push, q_valid, q_pop;
  vfc_pkg::cmd_t q_cmd, q_head;

  vfc_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_z     (in_cell_z),
    .in_block_type (in_block_type),
    .clr_busy      (clr_busy),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  vfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  vfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .clr_busy         (clr_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_face_side    (out_face_side),
    .out_face_x       (out_face_x),
    .out_face_y       (out_face_y),
    .out_face_z       (out_face_z),
    .out_first_vertex (out_first_vertex),
    .out_read_type    (out_read_type),
    .out_last         (out_last)
  );

  `VFC_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, clr_busy, in_stall, "input taken during clear")
  `VFC_ASSERT_IMP(a_read_is_last, clk, rst_n, out_valid && out_kind, out_last, "read not last")
  `VFC_ASSERT_IMP(a_face_side_range, clk, rst_n, out_valid && !out_kind, out_face_side < 3'd6 && out_read_type == '0, "bad face record")
  `VFC_ASSERT_NXT(a_push_fills_queue, clk, rst_n, q_push && !q_pop && !q_valid, q_valid, "queue lost a transaction")

endmodule
